### rtl/ophist_pkg.sv
// Shared constants and types for the order-five ordinal pattern histogram.
package ophist_pkg;

	localparam int MAX_DELAY_DEF    = 64;
	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH_DEF  = 32;

	// Window order five gives 5! patterns, one histogram bin each.
	localparam int NUM_BINS = 120;
	localparam int BIN_W    = 7;
	localparam int DELAY_W  = 7;
	localparam int ACTION_W = 2;

	typedef enum logic [ACTION_W-1:0] {
		ACT_PUSH  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2
	} action_t;

endpackage

### rtl/ophist_ram.sv
// Generic single-write, single-read RAM with registered read data.
module ophist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// A read and a write to the same address in one cycle return the old data.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/ophist_classify.sv
// Ordinal pattern classifier: ten signed comparisons and the fixed decision tree.
module ophist_classify #(
	parameter int SAMPLE_WIDTH = ophist_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic [4:0][SAMPLE_WIDTH-1:0] win,
	output logic [ophist_pkg::BIN_W-1:0] code
);
	import ophist_pkg::*;

	logic c10, c20, c21, c30, c31, c32, c40, c41, c42, c43;

	// Ties count as not less.
	assign c10 = $signed(win[1]) < $signed(win[0]);
	assign c20 = $signed(win[2]) < $signed(win[0]);
	assign c21 = $signed(win[2]) < $signed(win[1]);
	assign c30 = $signed(win[3]) < $signed(win[0]);
	assign c31 = $signed(win[3]) < $signed(win[1]);
	assign c32 = $signed(win[3]) < $signed(win[2]);
	assign c40 = $signed(win[4]) < $signed(win[0]);
	assign c41 = $signed(win[4]) < $signed(win[1]);
	assign c42 = $signed(win[4]) < $signed(win[2]);
	assign c43 = $signed(win[4]) < $signed(win[3]);

	always_comb begin
		if (c40) begin
			if (c30) begin
				if (c41) begin
					if (c20) begin
						if (c31) begin
							if (c42) begin
								if (c10) code = c21 ? (c32 ? (c43 ? 7'd0 : 7'd1) : 7'd2)
								                    : (c43 ? 7'd3 : 7'd4);
								else code = c32 ? (c43 ? 7'd5 : 7'd6) : 7'd7;
							end else begin
								if (c10) code = c32 ? 7'd8 : (c43 ? 7'd9 : 7'd10);
								else code = c32 ? 7'd11 : (c43 ? 7'd12 : 7'd13);
							end
						end else begin
							code = c42 ? (c21 ? 7'd14 : (c32 ? 7'd15 : 7'd16)) : 7'd17;
						end
					end else if (c31) begin
						code = c10 ? (c43 ? 7'd18 : 7'd19)
						           : (c21 ? (c43 ? 7'd20 : 7'd21) : (c43 ? 7'd22 : 7'd23));
					end else begin
						code = 7'd24;
					end
				end else if (c20) begin
					if (c31) code = c42 ? 7'd25 : (c21 ? (c32 ? 7'd26 : 7'd27) : 7'd28);
					else if (c42) code = c32 ? (c43 ? 7'd29 : 7'd30) : 7'd31;
					else code = c21 ? (c43 ? 7'd32 : 7'd33)
					                : (c32 ? 7'd34 : (c43 ? 7'd35 : 7'd36));
				end else begin
					code = c31 ? 7'd37 : (c43 ? 7'd38 : 7'd39);
				end
			end else if (c41) begin
				if (c20) begin
					if (c31) code = c42 ? 7'd40 : 7'd41;
					else if (c42) code = c10 ? (c21 ? 7'd42 : 7'd43) : 7'd44;
					else code = c10 ? 7'd45 : 7'd46;
				end else if (c31) begin
					code = c21 ? (c32 ? 7'd47 : 7'd48) : 7'd49;
				end else if (c10) begin
					code = c32 ? 7'd50 : 7'd51;
				end else begin
					code = c21 ? 7'd52 : (c32 ? 7'd53 : 7'd54);
				end
			end else if (c20) begin
				code = c42 ? 7'd55 : (c21 ? 7'd56 : 7'd57);
			end else begin
				code = c32 ? 7'd58 : 7'd59;
			end
		end else if (c30) begin
			if (c41) begin
				if (c20) code = c32 ? 7'd60 : 7'd61;
				else code = c42 ? (c21 ? 7'd62 : 7'd63) : 7'd64;
			end else if (c20) begin
				if (c31) begin
					if (c10) code = c21 ? (c32 ? 7'd65 : 7'd66) : 7'd67;
					else code = c32 ? 7'd68 : 7'd69;
				end else begin
					code = c21 ? 7'd70 : (c32 ? 7'd71 : 7'd72);
				end
			end else if (c31) begin
				if (c42) code = c10 ? 7'd73 : 7'd74;
				else code = c10 ? 7'd75 : (c21 ? 7'd76 : 7'd77);
			end else begin
				code = c42 ? 7'd78 : 7'd79;
			end
		end else if (c41) begin
			if (c20) begin
				code = c31 ? (c43 ? 7'd80 : 7'd81) : 7'd82;
			end else if (c31) begin
				if (c42) code = c21 ? (c32 ? (c43 ? 7'd83 : 7'd84) : 7'd85)
				                    : (c43 ? 7'd86 : 7'd87);
				else code = c32 ? 7'd88 : (c43 ? 7'd89 : 7'd90);
			end else begin
				code = c42 ? (c21 ? 7'd91 : (c32 ? 7'd92 : 7'd93)) : 7'd94;
			end
		end else if (c20) begin
			if (c31) code = 7'd95;
			else if (c10) code = c21 ? (c43 ? 7'd96 : 7'd97) : (c43 ? 7'd98 : 7'd99);
			else code = c43 ? 7'd100 : 7'd101;
		end else if (c31) begin
			code = c42 ? 7'd102 : (c21 ? (c32 ? 7'd103 : 7'd104) : 7'd105);
		end else if (c42) begin
			if (c10) code = c32 ? (c43 ? 7'd106 : 7'd107) : 7'd108;
			else code = c32 ? (c43 ? 7'd109 : 7'd110) : 7'd111;
		end else if (c10) begin
			code = c32 ? 7'd112 : (c43 ? 7'd113 : 7'd114);
		end else if (c21) begin
			code = c43 ? 7'd115 : 7'd116;
		end else begin
			code = c32 ? 7'd117 : (c43 ? 7'd118 : 7'd119);
		end
	end

endmodule

### rtl/ordinal_pattern_histogram_order5.sv
// Top level of the order-five ordinal pattern histogram.
// This block classifies a sample stream into ordinal patterns of order five and keeps a
// saturating 120-bin histogram of them. Every input beat carries an action in s_tuser:
// push a sample, read one bin, or clear the histogram and the sample window. Every input
// beat produces exactly one output beat, in order. A push that completes a window of five
// members spaced delay samples apart returns its pattern number and the bin count after
// the increment with the flag in m_tuser set; an incomplete window, a clear and the unused
// action return all zeros; a read returns the bin number and its count, or zero beyond the
// last bin. The block takes one beat per clock cycle while m_tready does not hold the
// output, and each beat passes through the registered stages in order: the accept stage
// reads the four older window members out of the sample store, stage 1 compares the
// window and looks up the pattern's bin, and stage 2 increments the bin, writes it back
// and loads the output register. The sample store is kept as four identical RAMs, one
// read port per older window member. Back-to-back hits on the same bin are forwarded, so
// they never need a stall; only a held output stalls the pipeline.
// Clearing is immediate; there is no clearing pass after reset. Write delay only while no
// beat is in flight; a value of zero acts as one and values above MAX_DELAY act as
// MAX_DELAY.
module ordinal_pattern_histogram_order5 #(
	parameter int MAX_DELAY    = ophist_pkg::MAX_DELAY_DEF,
	parameter int SAMPLE_WIDTH = ophist_pkg::SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = ophist_pkg::COUNT_WIDTH_DEF,
	localparam int IN_DATA_W   = ((SAMPLE_WIDTH + ophist_pkg::BIN_W + 7) / 8) * 8,
	localparam int OUT_DATA_W  = ((ophist_pkg::BIN_W + COUNT_WIDTH + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	// Configuration: delay register.
	input  logic                              cfg_we,
	input  logic [ophist_pkg::DELAY_W-1:0]    cfg_wdata,
	// Input stream.
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// s_tdata, low bit up: sample, bin_index, zero fill.
	input  logic [IN_DATA_W-1:0]              s_tdata,
	// s_tuser: action.
	input  logic [ophist_pkg::ACTION_W-1:0]   s_tuser,
	// Output stream.
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// m_tdata, low bit up: pattern_index, count, zero fill.
	output logic [OUT_DATA_W-1:0]             m_tdata,
	// m_tuser: pattern_valid.
	output logic [0:0]                        m_tuser
);
	import ophist_pkg::*;

	localparam int DEPTH = 4 * MAX_DELAY;
	localparam int AW    = $clog2(DEPTH);
	localparam int GW    = (MAX_DELAY > 1) ? $clog2(MAX_DELAY + 1) : 1;
	localparam int FW    = $clog2(DEPTH + 1);

	// ---------------------------------------------------------------------------------
	// Configuration. The clamped spacing is stored directly.
	// ---------------------------------------------------------------------------------
	logic [GW-1:0] gap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_q <= GW'(1);
		end else if (cfg_we) begin
			if (cfg_wdata == '0) gap_q <= GW'(1);
			else if (int'(cfg_wdata) > MAX_DELAY) gap_q <= GW'(MAX_DELAY);
			else gap_q <= GW'(cfg_wdata);
		end
	end

	// ---------------------------------------------------------------------------------
	// Handshake. Each stage moves on when the one after it is empty or moving.
	// ---------------------------------------------------------------------------------
	logic v_s1, v_s2, out_v_q;
	logic rdy_out, rdy_s2, rdy_s1;
	logic in_fire, mv_s1, mv_s2;

	assign rdy_out  = !out_v_q || m_tready;
	assign rdy_s2   = !v_s2 || rdy_out;
	assign rdy_s1   = !v_s1 || rdy_s2;
	assign s_tready = rdy_s1;
	assign in_fire  = s_tvalid && s_tready;
	assign mv_s1    = v_s1 && rdy_s2;
	assign mv_s2    = v_s2 && rdy_out;

	action_t                 act_in;
	logic [SAMPLE_WIDTH-1:0] sample_in;
	logic [BIN_W-1:0]        bin_in;

	assign act_in    = action_t'(s_tuser);
	assign sample_in = s_tdata[SAMPLE_WIDTH-1:0];
	assign bin_in    = s_tdata[SAMPLE_WIDTH+BIN_W-1:SAMPLE_WIDTH];

	// ---------------------------------------------------------------------------------
	// Accept stage: window addresses, completeness, store write, position counters.
	// ---------------------------------------------------------------------------------
	logic [AW-1:0] wp_q;
	logic [FW-1:0] fill_q;
	logic [3:0][AW-1:0] rd_addr;
	logic [AW:0]   back4;
	logic          complete_in;

	always_comb begin
		logic [AW:0] back;
		logic [AW:0] wp_ext;
		wp_ext = {1'b0, wp_q};
		back4  = '0;
		for (int k = 0; k < 4; k++) begin
			back = (AW+1)'(4 - k) * (AW+1)'(gap_q);
			if (k == 0) back4 = back;
			if (wp_ext >= back) rd_addr[k] = AW'(wp_ext - back);
			else rd_addr[k] = AW'(wp_ext + (AW+1)'(DEPTH) - back);
		end
	end

	assign complete_in = (AW+1)'(fill_q) >= back4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q   <= '0;
			fill_q <= '0;
		end else if (in_fire) begin
			case (act_in)
				ACT_PUSH: begin
					wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
					if (fill_q < FW'(DEPTH)) fill_q <= fill_q + FW'(1);
				end
				ACT_CLEAR: begin
					wp_q   <= '0;
					fill_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Four copies of the sample store, one per older window member.
	logic [4:0][SAMPLE_WIDTH-1:0] win_s1;

	for (genvar g = 0; g < 4; g++) begin : g_store
		ophist_ram #(
			.WIDTH(SAMPLE_WIDTH),
			.DEPTH(DEPTH)
		) u_store (
			.clk  (clk),
			.we   (in_fire && act_in == ACT_PUSH),
			.waddr(wp_q),
			.wdata(sample_in),
			.re   (in_fire),
			.raddr(rd_addr[g]),
			.rdata(win_s1[g])
		);
	end

	// ---------------------------------------------------------------------------------
	// Stage 1: classify the window and look up the bin.
	// ---------------------------------------------------------------------------------
	action_t                 act_s1;
	logic                    complete_s1;
	logic [BIN_W-1:0]        bin_s1;
	logic [SAMPLE_WIDTH-1:0] sample_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			act_s1      <= act_in;
			complete_s1 <= complete_in;
			bin_s1      <= bin_in;
			sample_s1   <= sample_in;
		end
	end

	assign win_s1[4] = sample_s1;

	logic [BIN_W-1:0] code_s1;

	ophist_classify #(
		.SAMPLE_WIDTH(SAMPLE_WIDTH)
	) u_classify (
		.win (win_s1),
		.code(code_s1)
	);

	logic             bin_ok_s1;
	logic [BIN_W-1:0] haddr_s1;

	assign bin_ok_s1 = int'(bin_s1) < NUM_BINS;
	always_comb begin
		if (act_s1 == ACT_READ) haddr_s1 = bin_ok_s1 ? bin_s1 : '0;
		else haddr_s1 = code_s1;
	end

	// ---------------------------------------------------------------------------------
	// Stage 2: increment, write back and form the result.
	// ---------------------------------------------------------------------------------
	action_t          act_s2;
	logic             complete_s2;
	logic             bin_ok_s2;
	logic [BIN_W-1:0] idx_s2;
	logic [BIN_W-1:0] haddr_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s1) begin
			act_s2      <= act_s1;
			complete_s2 <= complete_s1;
			bin_ok_s2   <= bin_ok_s1;
			idx_s2      <= (act_s1 == ACT_READ) ? bin_s1 : code_s1;
			haddr_s2    <= haddr_s1;
		end
	end

	logic [COUNT_WIDTH-1:0] hist_rdata;
	logic [COUNT_WIDTH-1:0] cur_cnt;
	logic [COUNT_WIDTH-1:0] new_cnt;
	logic                   hist_we;
	logic [NUM_BINS-1:0]    hvalid_q;
	logic                   fwd_v_q;
	logic [BIN_W-1:0]       fwd_addr_q;
	logic [COUNT_WIDTH-1:0] fwd_data_q;

	ophist_ram #(
		.WIDTH(COUNT_WIDTH),
		.DEPTH(NUM_BINS)
	) u_hist (
		.clk  (clk),
		.we   (hist_we),
		.waddr(haddr_s2),
		.wdata(new_cnt),
		.re   (mv_s1),
		.raddr(haddr_s1),
		.rdata(hist_rdata)
	);

	// The last write is always the newest value of its bin; a bin never written since
	// reset or the last clear reads as zero.
	always_comb begin
		if (fwd_v_q && fwd_addr_q == haddr_s2) cur_cnt = fwd_data_q;
		else if (hvalid_q[haddr_s2]) cur_cnt = hist_rdata;
		else cur_cnt = '0;
	end

	assign new_cnt = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);
	assign hist_we = mv_s2 && act_s2 == ACT_PUSH && complete_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hvalid_q <= '0;
			fwd_v_q  <= 1'b0;
		end else if (mv_s2 && act_s2 == ACT_CLEAR) begin
			hvalid_q <= '0;
			fwd_v_q  <= 1'b0;
		end else if (hist_we) begin
			hvalid_q[haddr_s2] <= 1'b1;
			fwd_v_q            <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (hist_we) begin
			fwd_addr_q <= haddr_s2;
			fwd_data_q <= new_cnt;
		end
	end

	// ---------------------------------------------------------------------------------
	// Output register.
	// ---------------------------------------------------------------------------------
	logic                   pvalid_q;
	logic [BIN_W-1:0]       idx_q;
	logic [COUNT_WIDTH-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (rdy_out) begin
			out_v_q <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (mv_s2) begin
			pvalid_q <= 1'b0;
			idx_q    <= '0;
			cnt_q    <= '0;
			case (act_s2)
				ACT_PUSH: begin
					if (complete_s2) begin
						pvalid_q <= 1'b1;
						idx_q    <= idx_s2;
						cnt_q    <= new_cnt;
					end
				end
				ACT_READ: begin
					idx_q <= idx_s2;
					if (bin_ok_s2) cnt_q <= cur_cnt;
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tuser  = pvalid_q;
	assign m_tdata  = OUT_DATA_W'({cnt_q, idx_q});

endmodule
